### rtl/image_patch_normalizer_top_assert.svh
// Assertion macros shared by the image patch normalizer RTL.
// Depends on the including module having i_clk and i_rst_n in scope.
`ifndef IMAGE_PATCH_NORMALIZER_TOP_ASSERT_SVH
`define IMAGE_PATCH_NORMALIZER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define IPN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that, when true, implies the consequent in the next cycle.
`define IPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ipn_pkg.sv
// Shared constants and types of the image patch normalizer.
// No dependencies; ipn_locate, ipn_lane and the top module refer to this package by scoped names.
package ipn_pkg;

    localparam int PATCH_DIM  = 16;
    localparam int PS_BITS    = $clog2(PATCH_DIM);

    localparam int X_W     = 12;
    localparam int CNT_W   = 13;
    localparam int PCOL_W  = X_W - PS_BITS;
    localparam int PIDX_W  = 24;
    localparam int POFF_W  = 8;

    localparam int BYTE_W  = 8;
    localparam int COEF_W  = 32;
    localparam int PROD_W  = BYTE_W + 1 + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int POS_W   = $clog2(MAG_W);

    localparam int FRAC_BITS = 24;
    localparam int BF16_BIAS = 127;
    localparam int BF16_W    = 16;
    localparam int MANT_W    = 7;
    localparam int EXP_W     = 8;

    localparam int LANES      = 3;
    localparam int PIPE_DEPTH = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]  PATCH_CNT_RST = CNT_W'(14);
    localparam logic [COEF_W-1:0] SCALE_RST     = COEF_W'(65793);
    localparam logic [COEF_W-1:0] OFFSET_RST    = '0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATCH_COLUMNS = 3'd0,
        CFG_PATCH_ROWS    = 3'd1,
        CFG_SCALE_RED     = 3'd2,
        CFG_SCALE_GREEN   = 3'd3,
        CFG_SCALE_BLUE    = 3'd4,
        CFG_OFFSET_RED    = 3'd5,
        CFG_OFFSET_GREEN  = 3'd6,
        CFG_OFFSET_BLUE   = 3'd7
    } t_cfg_idx;

    // Pipeline control shared by all lanes and the coordinate path.
    typedef struct packed {
        logic                  en;
        logic [PIPE_DEPTH-1:0] vld;
    } t_pipe_ctl;

endpackage

### rtl/ipn_locate.sv
// Patch coordinate path: patch number, offset inside the patch and grid check.
// Depends on ipn_pkg; delayed to match the depth of the ipn_lane pipeline.
module ipn_locate (
    input  logic                            i_clk,
    input  ipn_pkg::t_pipe_ctl              i_ctl,
    input  logic [ipn_pkg::X_W-1:0]         i_pixel_x,
    input  logic [ipn_pkg::X_W-1:0]         i_pixel_y,
    input  logic [ipn_pkg::CNT_W-1:0]       i_patch_columns,
    input  logic [ipn_pkg::CNT_W-1:0]       i_patch_rows,
    output logic [ipn_pkg::PIDX_W-1:0]      o_patch_index,
    output logic [ipn_pkg::POFF_W-1:0]      o_pixel_in_patch,
    output logic                            o_in_patch
);

    localparam int DLY = ipn_pkg::PIPE_DEPTH;

    logic [ipn_pkg::PCOL_W-1:0] w_pcol;
    logic [ipn_pkg::PCOL_W-1:0] w_prow;
    logic                       n_in;
    logic [ipn_pkg::PIDX_W-1:0] n_pidx;
    logic [ipn_pkg::POFF_W-1:0] n_poff;

    logic [ipn_pkg::PIDX_W-1:0] r_pidx [DLY];
    logic [ipn_pkg::POFF_W-1:0] r_poff [DLY];
    logic                       r_in   [DLY];

    assign w_pcol = i_pixel_x[ipn_pkg::X_W-1:ipn_pkg::PS_BITS];
    assign w_prow = i_pixel_y[ipn_pkg::X_W-1:ipn_pkg::PS_BITS];

    always_comb begin
        n_in   = (ipn_pkg::CNT_W'(w_pcol) < i_patch_columns)
              && (ipn_pkg::CNT_W'(w_prow) < i_patch_rows);
        n_pidx = ipn_pkg::PIDX_W'(w_prow) * ipn_pkg::PIDX_W'(i_patch_columns)
               + ipn_pkg::PIDX_W'(w_pcol);
        n_poff = ipn_pkg::POFF_W'({i_pixel_y[ipn_pkg::PS_BITS-1:0],
                                   i_pixel_x[ipn_pkg::PS_BITS-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pidx[0] <= n_pidx;
            r_poff[0] <= n_poff;
            r_in[0]   <= n_in;
            for (int k = 1; k < DLY; k++) begin
                r_pidx[k] <= r_pidx[k-1];
                r_poff[k] <= r_poff[k-1];
                r_in[k]   <= r_in[k-1];
            end
        end
    end

    assign o_patch_index    = r_pidx[DLY-1];
    assign o_pixel_in_patch = r_poff[DLY-1];
    assign o_in_patch       = r_in[DLY-1];

endmodule

### rtl/ipn_lane.sv
// One channel lane: byte * scale + offset in Q24 fixed point, then bfloat16 rounding.
// Depends on ipn_pkg and the assertion macros; four register stages.
`include "image_patch_normalizer_top_assert.svh"

module ipn_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ipn_pkg::t_pipe_ctl                 i_ctl,
    input  logic [ipn_pkg::BYTE_W-1:0]         i_byte,
    input  logic signed [ipn_pkg::COEF_W-1:0]  i_scale,
    input  logic signed [ipn_pkg::COEF_W-1:0]  i_offset,
    output logic [ipn_pkg::BF16_W-1:0]         o_res
);

    localparam int MAG_W  = ipn_pkg::MAG_W;
    localparam int POS_W  = ipn_pkg::POS_W;
    localparam int MANT_W = ipn_pkg::MANT_W;
    localparam int EXP_W  = ipn_pkg::EXP_W;
    localparam int KEEP_LO = MAG_W - 1 - MANT_W;
    localparam int EXP_ADJ = ipn_pkg::BF16_BIAS - ipn_pkg::FRAC_BITS;

    // Stage 1: exact fixed-point sum.
    logic signed [ipn_pkg::PROD_W-1:0] w_prod;
    logic signed [ipn_pkg::SUM_W-1:0]  n_sum1;
    logic signed [ipn_pkg::SUM_W-1:0]  r_sum1;

    // Stage 2: sign and magnitude.
    logic [MAG_W-1:0] n_mag2;
    logic [MAG_W-1:0] r_mag2;
    logic             r_neg2;
    logic             r_zero2;

    // Stage 3: leading one position.
    logic [POS_W-1:0] n_pos3;
    logic [POS_W-1:0] r_pos3;
    logic [MAG_W-1:0] r_mag3;
    logic             r_neg3;
    logic             r_zero3;

    // Stage 4: normalize and round to nearest even.
    logic [MAG_W-1:0]          w_norm;
    logic [EXP_W-1:0]          w_exp;
    logic                      w_guard;
    logic                      w_sticky;
    logic                      w_round;
    logic [EXP_W+MANT_W-1:0]   w_bits;
    logic [ipn_pkg::BF16_W-1:0] n_res4;
    logic [ipn_pkg::BF16_W-1:0] r_res4;

    assign w_prod = $signed({1'b0, i_byte}) * i_scale;
    assign n_sum1 = ipn_pkg::SUM_W'(w_prod) + ipn_pkg::SUM_W'(i_offset);

    assign n_mag2 = r_sum1[ipn_pkg::SUM_W-1] ? MAG_W'(-r_sum1) : MAG_W'(r_sum1);

    always_comb begin
        n_pos3 = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_mag2[i]) begin
                n_pos3 = POS_W'(i);
            end
        end
    end

    always_comb begin
        w_norm   = r_mag3 << (POS_W'(MAG_W - 1) - r_pos3);
        w_exp    = EXP_W'(r_pos3) + EXP_W'(EXP_ADJ);
        w_guard  = w_norm[KEEP_LO-1];
        w_sticky = |w_norm[KEEP_LO-2:0];
        w_round  = w_guard & (w_sticky | w_norm[KEEP_LO]);
        // A carry out of the mantissa moves into the exponent, as it should.
        w_bits   = {w_exp, w_norm[MAG_W-2:KEEP_LO]} + (EXP_W+MANT_W)'(w_round);
        n_res4   = r_zero3 ? '0 : {r_neg3, w_bits};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sum1  <= n_sum1;
            r_mag2  <= n_mag2;
            r_neg2  <= r_sum1[ipn_pkg::SUM_W-1];
            r_zero2 <= (r_sum1 == '0);
            r_pos3  <= n_pos3;
            r_mag3  <= r_mag2;
            r_neg3  <= r_neg2;
            r_zero3 <= r_zero2;
            r_res4  <= n_res4;
        end
    end

    assign o_res = r_res4;

    `IPN_ASSERT_ALWAYS(a_lead_one, !(i_ctl.vld[2] && !r_zero3) || ((r_mag3 >> r_pos3) == MAG_W'(1)), "leading one position is wrong")
    `IPN_ASSERT_ALWAYS(a_no_neg_zero, !(i_ctl.vld[3] && (o_res[ipn_pkg::BF16_W-2:0] == '0)) || !o_res[ipn_pkg::BF16_W-1], "negative zero produced")
    `IPN_ASSERT_ALWAYS(a_exp_range, !(i_ctl.vld[3] && (o_res != '0)) || ((o_res[14:7] >= EXP_W'(EXP_ADJ)) && (o_res[14:7] <= EXP_W'(EXP_ADJ + MAG_W))), "exponent outside the reachable range")

endmodule

### rtl/image_patch_normalizer_top.sv
// Image patch normalizer: three channel lanes, the patch coordinate path and the output merge.
// Depends on ipn_pkg, ipn_lane, ipn_locate and the assertion macros.
//
// Accepts one RGB pixel per clock unless a stalled result beat blocks the output, and delivers
// one result beat per pixel, in order, through the four register stages of each channel
// lane (multiply-add, magnitude, leading-one search, normalize and round).
// Three identical lanes work on red, green and blue side by side, and the output stage
// merges their bfloat16 values with the patch number and offset, forcing every field to
// zero for a pixel outside the whole-patch grid. A stall on the output freezes the
// whole pipeline, so i_ready low holds the result beat and stops input acceptance only
// when the last stage is full. Configuration registers are written through a plain
// write port and take effect for pixels accepted afterwards.
`include "image_patch_normalizer_top_assert.svh"

module image_patch_normalizer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [ipn_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ipn_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // pixel input
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ipn_pkg::X_W-1:0]            i_pixel_x,
    input  logic [ipn_pkg::X_W-1:0]            i_pixel_y,
    input  logic [ipn_pkg::BYTE_W-1:0]         i_red,
    input  logic [ipn_pkg::BYTE_W-1:0]         i_green,
    input  logic [ipn_pkg::BYTE_W-1:0]         i_blue,
    // result output
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ipn_pkg::PIDX_W-1:0]         o_patch_index,
    output logic [ipn_pkg::POFF_W-1:0]         o_pixel_in_patch,
    output logic [ipn_pkg::BF16_W-1:0]         o_norm_red,
    output logic [ipn_pkg::BF16_W-1:0]         o_norm_green,
    output logic [ipn_pkg::BF16_W-1:0]         o_norm_blue,
    output logic                               o_in_patch
);

    localparam int LANES = ipn_pkg::LANES;
    localparam int DEPTH = ipn_pkg::PIPE_DEPTH;

    logic [ipn_pkg::CNT_W-1:0]        r_patch_columns;
    logic [ipn_pkg::CNT_W-1:0]        r_patch_rows;
    logic signed [ipn_pkg::COEF_W-1:0] r_scale  [LANES];
    logic signed [ipn_pkg::COEF_W-1:0] r_offset [LANES];

    logic [DEPTH-1:0]                 r_vld;
    logic [DEPTH-1:0]                 n_vld;
    logic                             w_en;
    ipn_pkg::t_pipe_ctl               w_ctl;

    logic [ipn_pkg::BYTE_W-1:0]       w_byte [LANES];
    logic [ipn_pkg::BF16_W-1:0]       w_res  [LANES];
    logic [ipn_pkg::PIDX_W-1:0]       w_pidx;
    logic [ipn_pkg::POFF_W-1:0]       w_poff;
    logic                             w_in;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_columns <= ipn_pkg::PATCH_CNT_RST;
            r_patch_rows    <= ipn_pkg::PATCH_CNT_RST;
            for (int c = 0; c < LANES; c++) begin
                r_scale[c]  <= ipn_pkg::SCALE_RST;
                r_offset[c] <= ipn_pkg::OFFSET_RST;
            end
        end else if (i_cfg_we) begin
            unique case (ipn_pkg::t_cfg_idx'(i_cfg_addr))
                ipn_pkg::CFG_PATCH_COLUMNS: r_patch_columns <= i_cfg_wdata[ipn_pkg::CNT_W-1:0];
                ipn_pkg::CFG_PATCH_ROWS:    r_patch_rows    <= i_cfg_wdata[ipn_pkg::CNT_W-1:0];
                ipn_pkg::CFG_SCALE_RED:     r_scale[0]      <= i_cfg_wdata;
                ipn_pkg::CFG_SCALE_GREEN:   r_scale[1]      <= i_cfg_wdata;
                ipn_pkg::CFG_SCALE_BLUE:    r_scale[2]      <= i_cfg_wdata;
                ipn_pkg::CFG_OFFSET_RED:    r_offset[0]     <= i_cfg_wdata;
                ipn_pkg::CFG_OFFSET_GREEN:  r_offset[1]     <= i_cfg_wdata;
                ipn_pkg::CFG_OFFSET_BLUE:   r_offset[2]     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances unless a finished beat waits at the output.
    assign w_en    = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = w_en;
    assign n_vld   = {r_vld[DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    assign w_ctl.en  = w_en;
    assign w_ctl.vld = r_vld;

    assign w_byte[0] = i_red;
    assign w_byte[1] = i_green;
    assign w_byte[2] = i_blue;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ipn_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_byte   (w_byte[g]),
            .i_scale  (r_scale[g]),
            .i_offset (r_offset[g]),
            .o_res    (w_res[g])
        );
    end

    ipn_locate u_locate (
        .i_clk            (i_clk),
        .i_ctl            (w_ctl),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_patch_columns  (r_patch_columns),
        .i_patch_rows     (r_patch_rows),
        .o_patch_index    (w_pidx),
        .o_pixel_in_patch (w_poff),
        .o_in_patch       (w_in)
    );

    // Merge: a pixel outside the grid reports zeros in every field.
    assign o_valid          = r_vld[DEPTH-1];
    assign o_in_patch       = w_in;
    assign o_patch_index    = w_in ? w_pidx : '0;
    assign o_pixel_in_patch = w_in ? w_poff : '0;
    assign o_norm_red       = w_in ? w_res[0] : '0;
    assign o_norm_green     = w_in ? w_res[1] : '0;
    assign o_norm_blue      = w_in ? w_res[2] : '0;

    `IPN_ASSERT_NEXT(a_accept_enters, i_valid && o_ready, r_vld[0], "accepted beat did not enter the pipeline")
    `IPN_ASSERT_NEXT(a_stall_holds, o_valid && !i_ready, o_valid && $stable(w_res[0]) && $stable(w_pidx), "stalled result beat changed")
    `IPN_ASSERT_ALWAYS(a_stall_blocks, !(r_vld[DEPTH-1] && !i_ready) || !o_ready, "input accepted while output stage is blocked")

endmodule

### bench/ipn_tb_pkg.sv
// Scoreboard for the image patch normalizer bench: register shadow, pixel predictor
// and in-order result check. Depends on ipn_pkg for widths, reset values and register codes.
`timescale 1ns / 100ps

package ipn_tb_pkg;

    typedef struct packed {
        logic [ipn_pkg::PIDX_W-1:0] patch_index;
        logic [ipn_pkg::POFF_W-1:0] pixel_in_patch;
        logic [ipn_pkg::BF16_W-1:0] norm_red;
        logic [ipn_pkg::BF16_W-1:0] norm_green;
        logic [ipn_pkg::BF16_W-1:0] norm_blue;
        logic                       in_patch;
    } t_norm_result;

    class patch_norm_scoreboard;
        logic [ipn_pkg::CNT_W-1:0]         columns;
        logic [ipn_pkg::CNT_W-1:0]         rows;
        logic signed [ipn_pkg::COEF_W-1:0] scale[ipn_pkg::LANES];
        logic signed [ipn_pkg::COEF_W-1:0] offset[ipn_pkg::LANES];
        t_norm_result                      expected_q[$];
        int                                mismatches;

        function new();
            columns    = ipn_pkg::PATCH_CNT_RST;
            rows       = ipn_pkg::PATCH_CNT_RST;
            mismatches = 0;
            for (int c = 0; c < ipn_pkg::LANES; c++) begin
                scale[c]  = ipn_pkg::SCALE_RST;
                offset[c] = ipn_pkg::OFFSET_RST;
            end
        endfunction

        function void write_reg(ipn_pkg::t_cfg_idx idx, logic [ipn_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ipn_pkg::CFG_PATCH_COLUMNS: columns   = data[ipn_pkg::CNT_W-1:0];
                ipn_pkg::CFG_PATCH_ROWS:    rows      = data[ipn_pkg::CNT_W-1:0];
                ipn_pkg::CFG_SCALE_RED:     scale[0]  = data;
                ipn_pkg::CFG_SCALE_GREEN:   scale[1]  = data;
                ipn_pkg::CFG_SCALE_BLUE:    scale[2]  = data;
                ipn_pkg::CFG_OFFSET_RED:    offset[0] = data;
                ipn_pkg::CFG_OFFSET_GREEN:  offset[1] = data;
                ipn_pkg::CFG_OFFSET_BLUE:   offset[2] = data;
                default: ;
            endcase
        endfunction

        // Exact fixed-point sum with 24 fraction bits, rounded once to bfloat16.
        function logic [15:0] to_bf16(longint value);
            logic [63:0] mag, kept, rest, half;
            logic [15:0] sign_bit, bits;
            int          lead, shift;
            if (value == 0)
                return '0;
            sign_bit = (value < 0) ? 16'h8000 : 16'h0000;
            mag      = (value < 0) ? 64'(-value) : 64'(value);
            lead     = 0;
            for (int i = 0; i < 64; i++)
                if (mag[i])
                    lead = i;
            bits = 16'((ipn_pkg::BF16_BIAS + lead - ipn_pkg::FRAC_BITS) << ipn_pkg::MANT_W);
            if (lead <= ipn_pkg::MANT_W) begin
                kept = mag << (ipn_pkg::MANT_W - lead);
                bits = bits | 16'(kept[6:0]);
            end else begin
                shift = lead - ipn_pkg::MANT_W;
                kept  = mag >> shift;
                rest  = mag & ((64'd1 << shift) - 64'd1);
                half  = 64'd1 << (shift - 1);
                bits  = bits | 16'(kept[6:0]);
                // A round-up out of a full mantissa carries into the exponent.
                if (rest > half || (rest == half && kept[0]))
                    bits = bits + 16'd1;
            end
            return sign_bit | (bits & 16'h7FFF);
        endfunction

        function logic [15:0] lane_value(int lane, logic [7:0] level);
            return to_bf16(longint'(level) * longint'(scale[lane]) + longint'(offset[lane]));
        endfunction

        function t_norm_result predict(logic [11:0] x, logic [11:0] y,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_norm_result res;
            int unsigned  pcol, prow;
            res  = '0;
            pcol = x / ipn_pkg::PATCH_DIM;
            prow = y / ipn_pkg::PATCH_DIM;
            if (pcol >= columns || prow >= rows)
                return res;
            res.patch_index    = 24'(prow * columns + pcol);
            res.pixel_in_patch = 8'((y % ipn_pkg::PATCH_DIM) * ipn_pkg::PATCH_DIM
                                    + x % ipn_pkg::PATCH_DIM);
            res.norm_red       = lane_value(0, r);
            res.norm_green     = lane_value(1, g);
            res.norm_blue      = lane_value(2, b);
            res.in_patch       = 1'b1;
            return res;
        endfunction

        function void note_pixel(logic [11:0] x, logic [11:0] y,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
            expected_q.push_back(predict(x, y, r, g, b));
        endfunction

        function void report(string what, t_norm_result want, t_norm_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: expected idx=%h off=%h r=%h g=%h b=%h in=%b", $realtime,
                         what, want.patch_index, want.pixel_in_patch, want.norm_red,
                         want.norm_green, want.norm_blue, want.in_patch);
                $display("    actual idx=%h off=%h r=%h g=%h b=%h in=%b", got.patch_index,
                         got.pixel_in_patch, got.norm_red, got.norm_green, got.norm_blue,
                         got.in_patch);
            end
        endfunction

        function void check_result(t_norm_result got);
            t_norm_result want;
            if (expected_q.size() == 0) begin
                report("result beat with no pixel outstanding", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.patch_index !== want.patch_index || got.pixel_in_patch !== want.pixel_in_patch
                || got.norm_red !== want.norm_red || got.norm_green !== want.norm_green
                || got.norm_blue !== want.norm_blue || got.in_patch !== want.in_patch)
                report("result mismatch", want, got);
        endfunction

        function void flag_leftover();
            while (expected_q.size() != 0)
                report("pixel never produced a result", expected_q.pop_front(), '0);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int failures();
            return mismatches;
        endfunction
    endclass

endpackage

### bench/tb.sv
// Top-level bench for image_patch_normalizer_top: drives pixels and register writes,
// throttles both handshakes and checks every result beat. Depends on ipn_pkg and ipn_tb_pkg.
`timescale 1ns / 100ps

module tb;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [ipn_pkg::CFG_ADDR_W-1:0]     i_cfg_addr  = '0;
    logic [ipn_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                               i_valid     = 1'b0;
    logic                               o_ready;
    logic [ipn_pkg::X_W-1:0]            i_pixel_x   = '0;
    logic [ipn_pkg::X_W-1:0]            i_pixel_y   = '0;
    logic [ipn_pkg::BYTE_W-1:0]         i_red       = '0;
    logic [ipn_pkg::BYTE_W-1:0]         i_green     = '0;
    logic [ipn_pkg::BYTE_W-1:0]         i_blue      = '0;
    logic                               o_valid;
    logic                               i_ready     = 1'b0;
    logic [ipn_pkg::PIDX_W-1:0]         o_patch_index;
    logic [ipn_pkg::POFF_W-1:0]         o_pixel_in_patch;
    logic [ipn_pkg::BF16_W-1:0]         o_norm_red;
    logic [ipn_pkg::BF16_W-1:0]         o_norm_green;
    logic [ipn_pkg::BF16_W-1:0]         o_norm_blue;
    logic                               o_in_patch;

    ipn_tb_pkg::patch_norm_scoreboard board = new();
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    ipn_pkg::t_cfg_idx scale_reg_idx[3]  = '{ipn_pkg::CFG_SCALE_RED, ipn_pkg::CFG_SCALE_GREEN,
                                             ipn_pkg::CFG_SCALE_BLUE};
    ipn_pkg::t_cfg_idx offset_reg_idx[3] = '{ipn_pkg::CFG_OFFSET_RED, ipn_pkg::CFG_OFFSET_GREEN,
                                             ipn_pkg::CFG_OFFSET_BLUE};

    image_patch_normalizer_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_patch_index    (o_patch_index),
        .o_pixel_in_patch (o_pixel_in_patch),
        .o_norm_red       (o_norm_red),
        .o_norm_green     (o_norm_green),
        .o_norm_blue      (o_norm_blue),
        .o_in_patch       (o_in_patch)
    );

    always #5 i_clk = ~i_clk;

    // Both beats are sampled at the edge that accepts them, before any new drive lands.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            board.note_pixel(i_pixel_x, i_pixel_y, i_red, i_green, i_blue);
        if (i_rst_n && o_valid && i_ready)
            board.check_result('{o_patch_index, o_pixel_in_patch, o_norm_red, o_norm_green,
                                 o_norm_blue, o_in_patch});
    end

    // Result side: random stalls, plus an occasional long hold-off counted here.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #3000000;
        $display("tb failed");
        $finish;
    end

    function automatic logic [11:0] rand_coord(int unsigned count);
        int unsigned span;
        span = (count * ipn_pkg::PATCH_DIM > 4096) ? 4096 : count * ipn_pkg::PATCH_DIM;
        if (span != 0 && span < 4096 && $urandom_range(9) == 0)
            return 12'(span);
        if (span != 0 && $urandom_range(9) < 7)
            return 12'($urandom_range(span - 1));
        return 12'($urandom_range(4095));
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [12:0] rand_count();
        if ($urandom_range(3) == 0)
            return 13'($urandom_range(8191));
        return 13'($urandom_range(1, 40));
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(4))
            0:       return 32'($urandom_range(0, 1 << 20));
            1:       return -32'($urandom_range(0, 1 << 20));
            2: begin
                case ($urandom_range(4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0001;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 54; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 54; end
            default:       begin send_gap_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    task automatic write_reg(ipn_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(logic [12:0] cols, logic [12:0] rows);
        write_reg(ipn_pkg::CFG_PATCH_COLUMNS, 32'(cols));
        write_reg(ipn_pkg::CFG_PATCH_ROWS, 32'(rows));
    endtask

    task automatic set_lane(int lane, logic [31:0] scale, logic [31:0] offset);
        write_reg(scale_reg_idx[lane], scale);
        write_reg(offset_reg_idx[lane], offset);
    endtask

    task automatic random_config();
        set_grid(rand_count(), rand_count());
        for (int c = 0; c < 3; c++)
            set_lane(c, rand_coef(), rand_coef());
    endtask

    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_pixel(logic [11:0] x, logic [11:0] y,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        i_red     <= r;
        i_green   <= g;
        i_blue    <= b;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_pixel(rand_coord(board.columns), rand_coord(board.rows),
                       rand_byte(), rand_byte(), rand_byte());
        end_burst();
    endtask

    // Registers may only change once the pipeline has emptied.
    task automatic settle();
        for (int n = 0; n < 4000 && board.pending() != 0; n++)
            @(posedge i_clk);
        repeat (2 * ipn_pkg::PIPE_DEPTH) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 14 by 14 grid, scale near 1/255, no bias.
        set_idle(IDLE_NONE);
        send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd15, 12'd15, 8'h01, 8'h02, 8'h03);
        send_pixel(12'd16, 12'd0, 8'h80, 8'h7F, 8'h40);
        send_pixel(12'd0, 12'd16, 8'h10, 8'h20, 8'h30);
        send_pixel(12'd223, 12'd0, 8'hAA, 8'h55, 8'hC3);
        send_pixel(12'd223, 12'd223, 8'hFF, 8'h00, 8'h80);
        send_pixel(12'd224, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd0, 12'd224, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
        end_burst();
        settle();

        // Sums of 256 plus the byte at the lowest step: ties to even, ties that round
        // up, a carry into the exponent, the negative mirror and an exact zero.
        set_grid(13'd256, 13'd256);
        set_lane(0, 32'h0000_0001, 32'h0000_0100);
        set_lane(1, 32'hFFFF_FFFF, 32'hFFFF_FF00);
        set_lane(2, 32'h0000_0000, 32'h0000_0000);
        send_pixel(12'd0, 12'd0, 8'h81, 8'h81, 8'h81);
        send_pixel(12'd17, 12'd33, 8'h83, 8'h83, 8'h83);
        send_pixel(12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd4095, 12'd0, 8'h00, 8'h00, 8'h00);
        run_random(300);
        settle();

        // Largest grid and coefficient extremes, largest sums of either sign.
        set_grid(13'd8191, 13'd8191);
        set_lane(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_lane(1, 32'h8000_0000, 32'h8000_0000);
        set_lane(2, 32'h8000_0000, 32'h7FFF_FFFF);
        set_idle(IDLE_SENDER);
        send_pixel(12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(12'd1, 12'd4095, 8'h01, 8'h01, 8'h01);
        run_random(300);
        settle();

        // Grids with no columns, then no rows: every pixel lies outside.
        set_idle(IDLE_RECEIVER);
        set_grid(13'd0, 13'd5);
        run_random(60);
        settle();
        set_grid(13'd7, 13'd0);
        run_random(60);
        settle();

        // Typical per-channel mean and deviation.
        set_grid(13'd14, 13'd14);
        set_lane(0, 32'd287308, -32'd35532640);
        set_lane(1, 32'd293716, -32'd34153260);
        set_lane(2, 32'd292411, -32'd30273580);
        set_idle(IDLE_BOTH);
        run_random(300);
        settle();

        // Long result hold-off while pixels keep coming, so the input backs up.
        random_config();
        set_idle(IDLE_RECEIVER);
        hold_req = 300;
        run_random(300);
        settle();

        random_config();
        set_idle(IDLE_NONE);
        run_random(300);
        settle();

        random_config();
        set_idle(IDLE_BOTH);
        run_random(250);
        settle();

        board.flag_leftover();
        if (board.failures() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
